FILE: design/blau_pkg.sv
package blau_pkg;

    localparam int LIMB_W  = 14;
    localparam int OPB_W   = 16;
    localparam int CARRY_W = 16;
    localparam int OP_W    = 3;
    localparam int NUM_W   = 30;
    localparam int CNT_W   = $clog2(NUM_W + 1);

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_ZERO = 3'd4;

    localparam logic [OPB_W-1:0]   LIMB_BASE = 16'd10000;
    localparam logic [LIMB_W-1:0]  LIMB_MAX  = 14'd9999;
    localparam logic [CARRY_W-1:0] CARRY_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [OPB_W-1:0] den;
        logic             start;
    } t_div_req;

endpackage

FILE: design/blau_div.sv
module blau_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  blau_pkg::t_div_req         i_req,
    output logic                       o_done,
    output logic [blau_pkg::NUM_W-1:0] o_quot,
    output logic [blau_pkg::OPB_W-1:0] o_rem
);
    import blau_pkg::*;

    logic [NUM_W-1:0] r_quot, n_quot;
    logic [OPB_W-1:0] r_rem, n_rem;
    logic [OPB_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [OPB_W:0]   shifted;
    logic [OPB_W+1:0] trial;

    // One quotient bit per cycle: shift the next numerator bit into the
    // partial remainder and keep the difference when it does not borrow.
    always_comb begin
        shifted = {r_rem, r_quot[NUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_den};
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_quot = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[OPB_W+1]) begin
                n_rem  = trial[OPB_W-1:0];
                n_quot = {r_quot[NUM_W-2:0], 1'b1};
            end else begin
                n_rem  = shifted[OPB_W-1:0];
                n_quot = {r_quot[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

FILE: design/bignum_limb_arith_unit_top.sv
// Limb-serial base-10000 arithmetic unit.
// The input channel (i_in_valid / o_in_ready) takes one limb per transfer
// with its op code, first and last flags and the second operand. The output
// channel (o_out_valid / i_out_ready) returns one result limb per item with
// the running carry, borrow or remainder, the nonzero flag, the divide error
// flag and a copy of the last flag.
// Add, subtract with a negative difference, multiply and divide go through a
// bit-serial restoring divider that produces one quotient bit per cycle over
// a 30-bit numerator; such an item passes the prepare, divide and finish
// states, and its result is written from the finish state. Zero test,
// divide by zero and subtract without borrow skip the divider and go from
// the prepare state straight to the finish state. One item is worked on at
// a time: the next item is accepted only once the control is back in idle.
// The result sits in an output register, so the next item is accepted while
// a result waits; when the receiver stalls, the following item stops before
// writing its result until the register is free.
// Reset clears the running carry, the nonzero flag and the output valid flag and returns the control to idle.
module bignum_limb_arith_unit_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [blau_pkg::OP_W-1:0]    i_op,
    input  logic                         i_first,
    input  logic                         i_last,
    input  logic [blau_pkg::LIMB_W-1:0]  i_limb_a,
    input  logic [blau_pkg::OPB_W-1:0]   i_operand_b,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [blau_pkg::LIMB_W-1:0]  o_limb_out,
    output logic [blau_pkg::CARRY_W-1:0] o_carry_out,
    output logic                         o_nonzero,
    output logic                         o_div_error,
    output logic                         o_last_out
);
    import blau_pkg::*;

    t_state             r_state, n_state;
    logic [OP_W-1:0]    r_op;
    logic               r_last;
    logic [LIMB_W-1:0]  r_a;
    logic [OPB_W-1:0]   r_b;
    logic [CARRY_W-1:0] r_carry, n_carry;
    logic               r_nz, n_nz;
    logic               r_out_valid, n_out_valid;
    logic [LIMB_W-1:0]  r_limb_out;
    logic [CARRY_W-1:0] r_carry_out;
    logic               r_nz_out;
    logic               r_err_out;
    logic               r_last_out;

    logic               accept;
    logic               fin_en;
    logic               bypass;
    t_div_req           div_req;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    logic [OPB_W-1:0]   div_rem;

    logic [OPB_W-1:0]   mul_x, mul_y, mul_add;
    logic [31:0]        prod, prod_sum;
    logic [OPB_W:0]     sub_bc, sub_mag, sub_diff;
    logic               sub_neg;
    logic               b_zero;
    logic [LIMB_W-1:0]  fin_limb;
    logic [CARRY_W-1:0] fin_carry;
    logic               fin_err;

    blau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    assign sub_bc   = {1'b0, r_b} + {1'b0, r_carry};
    assign sub_neg  = sub_bc > {3'b000, r_a};
    assign sub_mag  = sub_bc - {3'b000, r_a};
    assign sub_diff = {3'b000, r_a} - sub_bc;
    assign b_zero   = (r_b == '0);

    always_comb begin
        if (r_op == OP_DIV) begin
            mul_x   = r_carry;
            mul_y   = LIMB_BASE;
            mul_add = {2'b00, r_a};
        end else begin
            mul_x   = {2'b00, r_a};
            mul_y   = r_b;
            mul_add = r_carry;
        end
        prod     = mul_x * mul_y;
        prod_sum = prod + {16'h0000, mul_add};
    end

    always_comb begin
        div_req.num = '0;
        div_req.den = LIMB_BASE;
        bypass      = 1'b0;
        case (r_op)
            OP_ADD: begin
                div_req.num = NUM_W'(r_a) + NUM_W'(r_b) + NUM_W'(r_carry);
            end
            OP_SUB: begin
                div_req.num = NUM_W'(sub_mag);
                bypass      = !sub_neg;
            end
            OP_MUL: begin
                div_req.num = prod_sum[NUM_W-1:0];
            end
            OP_DIV: begin
                div_req.num = prod_sum[NUM_W-1:0];
                div_req.den = r_b;
                bypass      = b_zero;
            end
            default: begin
                bypass = 1'b1;
            end
        endcase
        div_req.start = (r_state == S_PREP) && !bypass;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_PREP;
            S_PREP: n_state = bypass ? S_FIN : S_DIV;
            S_DIV:  if (div_done) n_state = S_FIN;
            S_FIN:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        fin_en     = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_FIN:   fin_en = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                fin_en     = 1'b0;
            end
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        fin_limb  = r_a;
        fin_carry = r_carry;
        fin_err   = 1'b0;
        case (r_op)
            OP_ADD: begin
                fin_limb  = div_rem[LIMB_W-1:0];
                fin_carry = div_quot[CARRY_W-1:0];
            end
            OP_SUB: begin
                if (!sub_neg) begin
                    fin_limb  = sub_diff[LIMB_W-1:0];
                    fin_carry = '0;
                end else if (div_rem == '0) begin
                    fin_limb  = '0;
                    fin_carry = div_quot[CARRY_W-1:0];
                end else begin
                    fin_limb  = LIMB_BASE[LIMB_W-1:0] - div_rem[LIMB_W-1:0];
                    fin_carry = div_quot[CARRY_W-1:0] + 1'b1;
                end
            end
            OP_MUL: begin
                fin_limb  = div_rem[LIMB_W-1:0];
                fin_carry = (div_quot > NUM_W'(CARRY_MAX)) ? CARRY_MAX
                                                           : div_quot[CARRY_W-1:0];
            end
            OP_DIV: begin
                if (b_zero) begin
                    fin_limb = '0;
                    fin_err  = 1'b1;
                end else begin
                    fin_limb  = (div_quot > NUM_W'(LIMB_MAX)) ? LIMB_MAX
                                                              : div_quot[LIMB_W-1:0];
                    fin_carry = div_rem;
                end
            end
            default: begin
                fin_limb = r_a;
            end
        endcase
    end

    always_comb begin
        n_carry     = r_carry;
        n_nz        = r_nz;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (accept && i_first) begin
            n_carry = '0;
            n_nz    = 1'b0;
        end
        if (fin_en) begin
            n_carry     = fin_carry;
            n_nz        = r_nz || (fin_limb != '0);
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_carry     <= '0;
            r_nz        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_carry     <= n_carry;
            r_nz        <= n_nz;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_op;
            r_last <= i_last;
            r_a    <= i_limb_a;
            r_b    <= i_operand_b;
        end
        if (fin_en) begin
            r_limb_out  <= fin_limb;
            r_carry_out <= fin_carry;
            r_nz_out    <= r_nz || (fin_limb != '0);
            r_err_out   <= fin_err;
            r_last_out  <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_limb_out  = r_limb_out;
    assign o_carry_out = r_carry_out;
    assign o_nonzero   = r_nz_out;
    assign o_div_error = r_err_out;
    assign o_last_out  = r_last_out;

endmodule
